// ===== rtl/u8u16_pkg.sv =====
package u8u16_pkg;

   localparam int MAX_UNITS = 4;
   localparam int POINT_W   = 21;
   localparam int UNIT_W    = 16;
   localparam int LEN_W     = 3;
   localparam int CNT_W     = $clog2(MAX_UNITS + 1);

   localparam logic [UNIT_W-1:0]  REPLACEMENT_UNIT = 16'hFFFD;
   localparam logic [UNIT_W-1:0]  HI_SURR_BASE     = 16'hD800;
   localparam logic [UNIT_W-1:0]  LO_SURR_BASE     = 16'hDC00;
   localparam logic [POINT_W-1:0] SUPPLEMENTARY    = 21'h10000;

   // sequence lengths held in the pending-length register
   localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
   localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
   localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

   typedef logic [UNIT_W-1:0] unit_type;
   typedef unit_type [MAX_UNITS-1:0] unit_list_type;

endpackage

// ===== rtl/utf8_to_utf16_decoder.sv =====
// UTF-8 to UTF-16 decoder.
// Input channel req_*: one UTF-8 byte per item, req_end_of_string set on the
// last byte of a string flushes any sequence still open as 0xFFFD units.
// Result channel rsp_*: one 16-bit UTF-16 unit per item; rsp_last_of_run
// marks the final unit caused by one input byte. A byte yields 0 to 4 units.
// Decoding of a byte is done in the cycle it is accepted; its units are
// loaded into a 4-entry result buffer and shown from the next cycle on.
// Throughput: one byte per cycle while each byte yields at most one unit
// and the receiver keeps rsp_ready high. A byte that yields N units occupies
// the result buffer until all N are taken; the next byte is taken in the
// same cycle the last of those units is taken. Bytes that yield nothing
// (lead and middle bytes of a sequence) leave the buffer empty and do not
// hold up the next byte.
// Reset clears the pending sequence and empties the result buffer.
// When the receiver holds rsp_ready low the buffer holds its units and
// req_ready drops once the last buffered unit is not being taken.
module utf8_to_utf16_decoder
   import u8u16_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_unit,
   output logic        rsp_last_of_run
);

   unit_list_type      units_ff, units_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [POINT_W-1:0] point_ff, point_in;
   logic [LEN_W-1:0]   exp_ff, exp_in;
   logic [LEN_W-1:0]   taken_ff, taken_in;

   // decoder outputs for the byte on the input ports
   unit_list_type      dec_units;
   logic [CNT_W-1:0]   dec_cnt;

   logic               req_fire, rsp_fire;

   assign rsp_valid       = (rem_ff != '0);
   assign rsp_unit        = units_ff[0];
   assign rsp_last_of_run = (rem_ff == CNT_W'(1));
   assign req_ready       = (rem_ff == '0) || (rsp_last_of_run && rsp_ready);
   assign req_fire        = req_valid && req_ready;
   assign rsp_fire        = rsp_valid && rsp_ready;

   // byte decode
   logic               is_cont;
   logic [POINT_W-1:0] cp;
   logic [POINT_W-1:0] v;
   logic [LEN_W-1:0]   taken_nx;
   logic [1:0]         n_flush;
   logic               lead_out;
   unit_type           lead_unit;

   always_comb begin
      is_cont   = (req_byte_in[7:6] == 2'b10);
      cp        = {point_ff[POINT_W-7:0], req_byte_in[5:0]};
      v         = cp - SUPPLEMENTARY;
      taken_nx  = taken_ff + LEN_W'(1);
      n_flush   = 2'd0;
      lead_out  = 1'b0;
      lead_unit = REPLACEMENT_UNIT;
      point_in  = point_ff;
      exp_in    = exp_ff;
      taken_in  = taken_ff;
      dec_units = {MAX_UNITS{REPLACEMENT_UNIT}};
      dec_cnt   = '0;

      if (exp_ff != LEN_NONE && is_cont) begin
         if (taken_nx >= exp_ff) begin
            point_in = '0;
            exp_in   = LEN_NONE;
            taken_in = '0;
            if (cp[POINT_W-1:16] != '0) begin
               dec_units[0] = HI_SURR_BASE + UNIT_W'(v[POINT_W-1:10]);
               dec_units[1] = LO_SURR_BASE + UNIT_W'(v[9:0]);
               dec_cnt      = CNT_W'(2);
            end else begin
               dec_units[0] = cp[UNIT_W-1:0];
               dec_cnt      = CNT_W'(1);
            end
         end else if (req_end_of_string) begin
            // cut short: one replacement per byte taken, this one included
            point_in = '0;
            exp_in   = LEN_NONE;
            taken_in = '0;
            dec_cnt  = CNT_W'(taken_nx);
         end else begin
            point_in = cp;
            taken_in = taken_nx;
         end
      end else begin
         // flush an open sequence, then treat the byte as a lead
         if (exp_ff != LEN_NONE) begin
            n_flush = taken_ff[1:0];
         end
         point_in = '0;
         exp_in   = LEN_NONE;
         taken_in = '0;
         if (!req_byte_in[7]) begin
            lead_out  = 1'b1;
            lead_unit = UNIT_W'(req_byte_in);
         end else if (req_byte_in[7:5] == 3'b110 && !req_end_of_string) begin
            point_in = POINT_W'(req_byte_in[4:0]);
            exp_in   = LEN_TWO;
            taken_in = LEN_W'(1);
         end else if (req_byte_in[7:4] == 4'b1110 && !req_end_of_string) begin
            point_in = POINT_W'(req_byte_in[3:0]);
            exp_in   = LEN_THREE;
            taken_in = LEN_W'(1);
         end else if (req_byte_in[7:3] == 5'b11110 && !req_end_of_string) begin
            point_in = POINT_W'(req_byte_in[2:0]);
            exp_in   = LEN_FOUR;
            taken_in = LEN_W'(1);
         end else begin
            // bad lead, or a multi-byte lead that ends the string
            lead_out = 1'b1;
         end
         for (int i = 0; i < MAX_UNITS; i++) begin
            if (lead_out && (n_flush == i[1:0])) begin
               dec_units[i] = lead_unit;
            end
         end
         dec_cnt = CNT_W'(n_flush) + CNT_W'(lead_out);
      end
   end

   // result buffer: loaded from the decoder when a byte is taken, else shifts down one unit per taken result
   always_comb begin
      units_in = units_ff;
      rem_in   = rem_ff;
      if (req_fire) begin
         units_in = dec_units;
         rem_in   = dec_cnt;
      end else if (rsp_fire) begin
         for (int i = 0; i < MAX_UNITS - 1; i++) begin
            units_in[i] = units_ff[i+1];
         end
         rem_in = rem_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      units_ff <= units_in;
      if (reset) begin
         rem_ff   <= '0;
         point_ff <= '0;
         exp_ff   <= LEN_NONE;
         taken_ff <= '0;
      end else begin
         rem_ff <= rem_in;
         if (req_fire) begin
            point_ff <= point_in;
            exp_ff   <= exp_in;
            taken_ff <= taken_in;
         end
      end
   end

   // an open sequence has its lead taken and is not yet complete
   assert property (@(posedge clock) disable iff (reset)
      exp_ff != LEN_NONE |-> exp_ff >= LEN_TWO && taken_ff != '0 && taken_ff < exp_ff)
      else $error("pending sequence bookkeeping inconsistent");

   // a byte is never taken while more than one unit is still buffered
   assert property (@(posedge clock) disable iff (reset)
      rem_ff > CNT_W'(1) |-> !req_ready)
      else $error("byte accepted with units still buffered");

   // a run does not end before its flagged last unit
   assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_last_of_run |=> rsp_valid)
      else $error("run of units ended without last_of_run");

endmodule

// ===== tb/tb_utf8_to_utf16_decoder.sv =====
`timescale 1ns / 100ps

module tb_utf8_to_utf16_decoder;
   import u8u16_pkg::*;

   typedef struct {
      unit_type unit;
      logic     is_last;
   } utf16_unit_type;

   // Tracks the UTF-8 decode state and holds the UTF-16 units still owed.
   class utf16_unit_checker;
      logic [POINT_W-1:0] cp_bits;
      logic [LEN_W-1:0]   seq_len;
      logic [LEN_W-1:0]   seq_taken;
      unit_type           run_units[$];
      utf16_unit_type     expected_units[$];
      int                 mismatches;

      function new();
         clear_pending();
         mismatches = 0;
      endfunction

      task report(string msg);
         $display("%0t ns mismatch: %s", $time, msg);
         mismatches++;
      endtask

      function void clear_pending();
         cp_bits   = '0;
         seq_len   = LEN_NONE;
         seq_taken = '0;
      endfunction

      function void add_unit(unit_type u);
         run_units.insert(run_units.size(), u);
      endfunction

      // one replacement per byte already taken into the open sequence
      function void flush_pending();
         repeat (seq_taken) add_unit(REPLACEMENT_UNIT);
         clear_pending();
      endfunction

      function void take_lead(logic [7:0] b, logic eos);
         logic [LEN_W-1:0]   len;
         logic [POINT_W-1:0] bits;
         len  = LEN_NONE;
         bits = '0;
         if (!b[7]) begin
            add_unit(unit_type'(b));
            return;
         end
         if (b[7:5] == 3'b110) begin
            len  = LEN_TWO;
            bits = POINT_W'(b[4:0]);
         end else if (b[7:4] == 4'b1110) begin
            len  = LEN_THREE;
            bits = POINT_W'(b[3:0]);
         end else if (b[7:3] == 5'b11110) begin
            len  = LEN_FOUR;
            bits = POINT_W'(b[2:0]);
         end
         // bad lead, or a multi-byte lead that ends the string
         if (len == LEN_NONE || eos) begin
            add_unit(REPLACEMENT_UNIT);
         end else begin
            cp_bits   = bits;
            seq_len   = len;
            seq_taken = LEN_W'(1);
         end
      endfunction

      function void note_byte(logic [7:0] b, logic eos);
         logic [POINT_W-1:0] v;
         utf16_unit_type     entry;
         run_units.delete();
         if (seq_len != LEN_NONE && b[7:6] == 2'b10) begin
            cp_bits   = {cp_bits[POINT_W-7:0], b[5:0]};
            seq_taken = seq_taken + LEN_W'(1);
            if (seq_taken >= seq_len) begin
               if (cp_bits >= SUPPLEMENTARY) begin
                  v = cp_bits - SUPPLEMENTARY;
                  add_unit(HI_SURR_BASE + unit_type'(v >> 10));
                  add_unit(LO_SURR_BASE + unit_type'(v[9:0]));
               end else begin
                  add_unit(unit_type'(cp_bits));
               end
               clear_pending();
            end else if (eos) begin
               flush_pending();
            end
         end else begin
            // a non-continuation byte breaks an open sequence, then acts as a lead
            if (seq_len != LEN_NONE) flush_pending();
            take_lead(b, eos);
         end
         foreach (run_units[i]) begin
            entry.unit    = run_units[i];
            entry.is_last = (i == run_units.size() - 1);
            expected_units.insert(expected_units.size(), entry);
         end
      endfunction

      task check_unit(unit_type unit, logic is_last);
         utf16_unit_type want;
         if (expected_units.size() == 0) begin
            report($sformatf("unit %h with none outstanding", unit));
            return;
         end
         want = expected_units.pop_front();
         if (unit !== want.unit)
            report($sformatf("unit %h, wanted %h", unit, want.unit));
         if (is_last !== want.is_last)
            report($sformatf("last_of_run %b, wanted %b (unit %h)", is_last, want.is_last,
                             want.unit));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_byte_in;
   logic        req_end_of_string;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_unit;
   logic        rsp_last_of_run;

   utf16_unit_checker units = new();

   logic [7:0] str_bytes[$];
   int         bytes_sent;
   bit         tx_idle;
   bit         rx_idle;
   bit         rx_hold;

   utf8_to_utf16_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_byte_in       (req_byte_in),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_unit          (rsp_unit),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(2_000_000);
      $display("tb_utf8_to_utf16_decoder failed");
      $finish;
   end

   // Valid is left high after the item is taken; the caller either offers the
   // next item in the same step or calls wait_drained, which lowers it.
   task send_byte(logic [7:0] b, logic eos);
      int gap;
      gap = tx_idle ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_byte_in       <= b;
      req_end_of_string <= eos;
      do @(posedge clock); while (!req_ready);
      units.note_byte(b, eos);
      bytes_sent++;
   endtask

   task send_string();
      foreach (str_bytes[i]) send_byte(str_bytes[i], i == str_bytes.size() - 1);
   endtask

   task wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (units.expected_units.size() != 0);
   endtask

   function void add_byte(logic [7:0] b);
      str_bytes.insert(str_bytes.size(), b);
   endfunction

   // Mostly well-formed characters of random length and content (overlong and
   // out-of-range forms included); the rest truncated, stray or junk bytes.
   function void add_random_char();
      int kind;
      int len;
      int keep;
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 4);
      if (kind == 8) begin
         add_byte(8'($urandom));
         return;
      end
      if (kind == 9) begin
         if ($urandom_range(1))
            add_byte(8'($urandom_range(8'hBF, 8'h80)));
         else
            add_byte(8'($urandom_range(8'hFF, 8'hF8)));
         return;
      end
      keep = len;
      if (kind == 7) begin
         len  = $urandom_range(2, 4);
         keep = $urandom_range(1, len - 1);
      end
      case (len)
         1: add_byte({1'b0, 7'($urandom)});
         2: add_byte({3'b110, 5'($urandom)});
         3: add_byte({4'b1110, 4'($urandom)});
         default: add_byte({5'b11110, 3'($urandom)});
      endcase
      repeat (keep - 1) add_byte({2'b10, 6'($urandom)});
   endfunction

   task send_random_bytes(int count);
      int stop_at;
      int nchars;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) begin
         str_bytes.delete();
         nchars = $urandom_range(1, 6);
         repeat (nchars) add_random_char();
         send_string();
      end
   endtask

   // result side: random stalls per item, plus one long hold on request
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rx_idle ? $urandom_range(0, 13) : 0;
         if (rx_hold) begin
            stall   = 80;
            rx_hold = 1'b0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         units.check_unit(rsp_unit, rsp_last_of_run);
      end
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_byte_in       = '0;
      req_end_of_string = 1'b0;
      bytes_sent        = 0;
      tx_idle           = 1'b1;
      rx_idle           = 1'b1;
      rx_hold           = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ASCII extremes
      str_bytes = '{8'h00, 8'h7F};
      send_string();
      // complete 2-, 3- and 4-byte characters, the last one a surrogate pair
      str_bytes = '{8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
      send_string();
      // continuation byte seen as a lead
      str_bytes = '{8'h80};
      send_string();
      // broken 3-byte sequence, the breaking byte then decodes as ASCII
      str_bytes = '{8'hE2, 8'h82, 8'h41};
      send_string();
      // lead byte ending the string
      str_bytes = '{8'hC3};
      send_string();
      // string ends after a good continuation, sequence unfinished
      str_bytes = '{8'hE2, 8'h82};
      send_string();
      // largest 4-byte value, beyond the Unicode range
      str_bytes = '{8'hF7, 8'hBF, 8'hBF, 8'hBF};
      send_string();
      // three replacements for the broken sequence plus one for the bad lead
      str_bytes = '{8'hF0, 8'h90, 8'h80, 8'hFF};
      send_string();
      wait_drained();

      tx_idle = 1'b0;
      rx_idle = 1'b0;
      send_random_bytes(15);
      wait_drained();

      tx_idle = 1'b1;
      rx_idle = 1'b0;
      send_random_bytes(15);
      wait_drained();

      // long receiver hold while bytes keep coming: input side must back up
      tx_idle = 1'b0;
      rx_hold = 1'b1;
      send_random_bytes(12);
      wait_drained();

      tx_idle = 1'b0;
      rx_idle = 1'b1;
      send_random_bytes(15);
      wait_drained();

      tx_idle = 1'b1;
      rx_idle = 1'b1;
      send_random_bytes(15);
      wait_drained();

      repeat (8) @(posedge clock);
      if (units.mismatches == 0)
         $display("tb_utf8_to_utf16_decoder passed");
      else
         $display("tb_utf8_to_utf16_decoder failed");
      $finish;
   end

endmodule

// ===== utf8_to_utf16_decoder.f =====
rtl/u8u16_pkg.sv
rtl/utf8_to_utf16_decoder.sv
tb/tb_utf8_to_utf16_decoder.sv
